FILE: rtl/core/alat_pkg.sv
// ----------------------------------------------------------------------------
// Aging life automaton package
// Shared sizes, codes and item types for the toroidal aging life grid.
// ----------------------------------------------------------------------------
package alat_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int DIM_BITS   = 7;
   localparam int K_BITS     = ROW_BITS + 1;
   localparam int AGE_BITS   = 8;
   localparam int COUNT_BITS = 13;
   localparam int GEN_BITS   = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [DIM_BITS-1:0] DIM_MIN     = DIM_BITS'(3);
   localparam logic [DIM_BITS-1:0] DIM_MAX_W   = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] DIM_MAX_H   = DIM_BITS'(MAX_HEIGHT);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // item function codes
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_GEN   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_AGE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_W  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_H  = 2'd2;

   // column probed by each read of a generation sweep
   localparam logic [1:0] PH_LEFT   = 2'd0;
   localparam logic [1:0] PH_CENTER = 2'd1;
   localparam logic [1:0] PH_RIGHT  = 2'd2;

   typedef struct packed {
      logic [1:0]          func;
      logic [COL_BITS-1:0] cell_x;
      logic [ROW_BITS-1:0] cell_y;
      logic [AGE_BITS-1:0] cell_age;
   } req_item_type;

   typedef struct packed {
      logic [AGE_BITS-1:0]   read_age;
      logic [COUNT_BITS-1:0] alive_count;
      logic [GEN_BITS-1:0]   generation;
   } rsp_item_type;

   // tag of a grid read issued by the generation sweep
   typedef struct packed {
      logic                 valid;
      logic [1:0]           phase;
      logic                 emit;
      logic [ADDR_BITS-1:0] addr;
   } probe_tag_type;

   // next-grid write from the rule stage
   typedef struct packed {
      logic                 we;
      logic                 alive;
      logic [ADDR_BITS-1:0] addr;
      logic [AGE_BITS-1:0]  age;
   } cell_wr_type;

endpackage

FILE: rtl/core/alat_ram.sv
// ----------------------------------------------------------------------------
// Grid RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module alat_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/alat_rule.sv
// ----------------------------------------------------------------------------
// Life rule stage
// Builds a three-row neighbour window from probed cells and registers the
// next age of each centre cell for the scratch grid.
// ----------------------------------------------------------------------------
module alat_rule (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [alat_pkg::AGE_BITS-1:0] max_age,
   input  alat_pkg::probe_tag_type      tag,
   input  logic [alat_pkg::AGE_BITS-1:0] cell_age,
   output alat_pkg::cell_wr_type        cell_wr
);
   import alat_pkg::*;

   logic                we_ff;
   logic                alive_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [AGE_BITS-1:0]  age_ff;
   logic                stg_l_ff;
   logic                stg_c_ff;
   logic [AGE_BITS-1:0]  stg_age_ff;
   logic [2:0]           mid_bits_ff;
   logic [2:0]           bot_bits_ff;
   logic [AGE_BITS-1:0]  bot_age_ff;

   logic                new_bit;
   logic [7:0]           nbr;
   logic [3:0]           nbr_count;
   logic [AGE_BITS-1:0]  next_age;
   logic                row_done;

   assign new_bit  = (cell_age != '0);
   assign row_done = tag.valid && (tag.phase == PH_RIGHT);

   // old middle row is the top of the window, old bottom row the centre row
   assign nbr = {mid_bits_ff, bot_bits_ff[2], bot_bits_ff[0], stg_l_ff, stg_c_ff, new_bit};

   always_comb begin
      nbr_count = '0;
      for (int i = 0; i < 8; i++) begin
         nbr_count = nbr_count + {3'b000, nbr[i]};
      end
      next_age = '0;
      if ((nbr_count == 4'd3) || ((bot_age_ff != '0) && (nbr_count == 4'd2))) begin
         next_age = (bot_age_ff < max_age) ? bot_age_ff + 8'd1 : max_age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         we_ff <= 1'b0;
      end else begin
         we_ff <= row_done && tag.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (tag.valid) begin
         case (tag.phase)
            PH_LEFT: begin
               stg_l_ff <= new_bit;
            end
            PH_CENTER: begin
               stg_c_ff   <= new_bit;
               stg_age_ff <= cell_age;
            end
            PH_RIGHT: begin
               // shift the window down one row
               mid_bits_ff <= bot_bits_ff;
               bot_bits_ff <= {stg_l_ff, stg_c_ff, new_bit};
               bot_age_ff  <= stg_age_ff;
               addr_ff     <= tag.addr;
               age_ff      <= next_age;
               alive_ff    <= (next_age != '0);
            end
            default: begin
               stg_l_ff <= stg_l_ff;
            end
         endcase
      end
   end

   assign cell_wr = '{we: we_ff, alive: alive_ff, addr: addr_ff, age: age_ff};

endmodule

FILE: rtl/core/aging_life_automaton_torus.sv
// ----------------------------------------------------------------------------
// Aging life automaton on a torus
// Write and read: the cell address is wrapped into the grid (the wrap subtracts
// the grid size once a cycle), then the result is strobed. Clear: the whole
// grid is zeroed. Generation: three grid reads per cell through the single
// read port, then a copy back from the scratch grid.
// After reset the grid is zeroed by a sweep with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module aging_life_automaton_torus (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  alat_pkg::req_item_type            req_item,
   output logic                              rsp_strobe,
   output alat_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [alat_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [alat_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import alat_pkg::*;

   typedef enum logic [8:0] {
      ST_INIT       = 9'b000000001,
      ST_IDLE       = 9'b000000010,
      ST_WRAP       = 9'b000000100,
      ST_RD_WAIT    = 9'b000001000,
      ST_GEN        = 9'b000010000,
      ST_GEN_DRAIN  = 9'b000100000,
      ST_COPY       = 9'b001000000,
      ST_COPY_DRAIN = 9'b010000000,
      ST_CLEAR      = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic [AGE_BITS-1:0]     max_age_ff, max_age_in;
   logic [DIM_BITS-1:0]     grid_w_ff, grid_w_in;
   logic [DIM_BITS-1:0]     grid_h_ff, grid_h_in;
   logic [COUNT_BITS-1:0]   live_ff, live_in;
   logic [GEN_BITS-1:0]     gen_ff, gen_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AGE_BITS-1:0]     rsp_age_ff, rsp_age_in;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   probe_tag_type          tag_ff, tag_in;
   logic                   copy_v_ff, copy_v_in;
   logic [ADDR_BITS-1:0]    copy_addr_ff, copy_addr_in;

   logic [1:0]              func_ff, func_in;
   logic [COL_BITS-1:0]     x_ff, x_in;
   logic [ROW_BITS-1:0]     y_ff, y_in;
   logic [AGE_BITS-1:0]     age_ff, age_in;
   logic [COL_BITS-1:0]     col_ff, col_in;
   logic [K_BITS-1:0]       k_ff, k_in;
   logic [1:0]              phase_ff, phase_in;
   logic [COL_BITS-1:0]     cx_ff, cx_in;
   logic [ROW_BITS-1:0]     cy_ff, cy_in;
   logic                   drain_ff, drain_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;

   logic [DIM_BITS-1:0]     eff_w, eff_h, w_last, h_last;
   logic [DIM_BITS-1:0]     x_diff, y_diff, xr_sum;
   logic                   x_ok, y_ok;
   logic [COL_BITS-1:0]     col_l, col_r, probe_col;
   logic [ROW_BITS-1:0]     probe_row;
   logic [K_BITS-1:0]       y_of_k;

   logic                   cur_we;
   logic [ADDR_BITS-1:0]    cur_waddr, cur_raddr;
   logic [AGE_BITS-1:0]     cur_wdata, cur_rdata;
   logic [ADDR_BITS-1:0]    nxt_raddr;
   logic [AGE_BITS-1:0]     nxt_rdata;
   cell_wr_type            rule_wr;

   alat_ram #(.DATA_W(AGE_BITS), .ADDR_W(ADDR_BITS)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_addr (cur_raddr),
      .rd_data (cur_rdata)
   );

   alat_ram #(.DATA_W(AGE_BITS), .ADDR_W(ADDR_BITS)) u_nxt_ram (
      .clock   (clock),
      .wr_en   (rule_wr.we),
      .wr_addr (rule_wr.addr),
      .wr_data (rule_wr.age),
      .rd_addr (nxt_raddr),
      .rd_data (nxt_rdata)
   );

   alat_rule u_rule (
      .clock    (clock),
      .reset    (reset),
      .max_age  (max_age_ff),
      .tag      (tag_ff),
      .cell_age (cur_rdata),
      .cell_wr  (rule_wr)
   );

   // clamp the grid size to the supported range
   always_comb begin
      if (grid_w_ff < DIM_MIN) begin
         eff_w = DIM_MIN;
      end else if (grid_w_ff > DIM_MAX_W) begin
         eff_w = DIM_MAX_W;
      end else begin
         eff_w = grid_w_ff;
      end
      if (grid_h_ff < DIM_MIN) begin
         eff_h = DIM_MIN;
      end else if (grid_h_ff > DIM_MAX_H) begin
         eff_h = DIM_MAX_H;
      end else begin
         eff_h = grid_h_ff;
      end
   end

   assign w_last = eff_w - DIM_BITS'(1);
   assign h_last = eff_h - DIM_BITS'(1);
   assign x_ok   = ({1'b0, x_ff} < eff_w);
   assign y_ok   = ({1'b0, y_ff} < eff_h);
   assign x_diff = {1'b0, x_ff} - eff_w;
   assign y_diff = {1'b0, y_ff} - eff_h;

   // wrapped neighbour columns and the centre row whose result is written at sweep step k
   assign xr_sum = {1'b0, col_ff} + DIM_BITS'(1);
   assign col_l  = (col_ff == '0) ? w_last[COL_BITS-1:0] : col_ff - COL_BITS'(1);
   assign col_r  = (xr_sum == eff_w) ? '0 : xr_sum[COL_BITS-1:0];
   assign y_of_k = k_ff - K_BITS'(2);

   always_comb begin
      case (phase_ff)
         PH_LEFT:  probe_col = col_l;
         PH_RIGHT: probe_col = col_r;
         default:  probe_col = col_ff;
      endcase
      if (k_ff == '0) begin
         probe_row = h_last[ROW_BITS-1:0];
      end else if (k_ff <= eff_h) begin
         probe_row = ROW_BITS'(k_ff - K_BITS'(1));
      end else begin
         probe_row = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      max_age_in   = max_age_ff;
      grid_w_in    = grid_w_ff;
      grid_h_in    = grid_h_ff;
      live_in      = live_ff;
      gen_in       = gen_ff;
      rsp_valid_in = 1'b0;
      rsp_age_in   = rsp_age_ff;
      clr_in       = clr_ff;
      tag_in       = '0;
      copy_v_in    = 1'b0;
      copy_addr_in = copy_addr_ff;
      func_in      = func_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      age_in       = age_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      phase_in     = phase_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      drain_in     = drain_ff;
      total_in     = total_ff;
      cur_we       = 1'b0;
      cur_waddr    = {x_ff, y_ff};
      cur_wdata    = age_ff;
      cur_raddr    = {x_ff, y_ff};
      nxt_raddr    = {cx_ff, cy_ff};

      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_AGE: max_age_in = csr_data;
            CSR_GRID_W:  grid_w_in  = csr_data[DIM_BITS-1:0];
            CSR_GRID_H:  grid_h_in  = csr_data[DIM_BITS-1:0];
            default:     max_age_in = max_age_ff;
         endcase
      end

      case (state_ff)
         ST_INIT: begin
            cur_we    = 1'b1;
            cur_waddr = clr_ff;
            cur_wdata = '0;
            clr_in    = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               func_in = req_item.func;
               x_in    = req_item.cell_x;
               y_in    = req_item.cell_y;
               age_in  = req_item.cell_age;
               case (req_item.func)
                  FUNC_WRITE, FUNC_READ: begin
                     state_in = ST_WRAP;
                  end
                  FUNC_GEN: begin
                     col_in   = '0;
                     k_in     = '0;
                     phase_in = PH_LEFT;
                     total_in = '0;
                     state_in = ST_GEN;
                  end
                  FUNC_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_WRAP: begin
            if (!x_ok) begin
               x_in = x_diff[COL_BITS-1:0];
            end
            if (!y_ok) begin
               y_in = y_diff[ROW_BITS-1:0];
            end
            if (x_ok && y_ok) begin
               if (func_ff == FUNC_WRITE) begin
                  cur_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_age_in   = '0;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_RD_WAIT;
               end
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_age_in   = cur_rdata;
            state_in     = ST_IDLE;
         end
         ST_GEN: begin
            cur_raddr = {probe_col, probe_row};
            tag_in    = '{valid: 1'b1, phase: phase_ff, emit: (k_ff >= K_BITS'(2)),
                          addr: {col_ff, y_of_k[ROW_BITS-1:0]}};
            if (phase_ff == PH_RIGHT) begin
               phase_in = PH_LEFT;
               if (k_ff == eff_h + DIM_BITS'(1)) begin
                  k_in = '0;
                  if ({1'b0, col_ff} == w_last) begin
                     drain_in = 1'b0;
                     state_in = ST_GEN_DRAIN;
                  end else begin
                     col_in = col_ff + COL_BITS'(1);
                  end
               end else begin
                  k_in = k_ff + K_BITS'(1);
               end
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_GEN_DRAIN: begin
            // wait for the last rule result to land in the scratch grid
            drain_in = 1'b1;
            if (drain_ff) begin
               cx_in    = '0;
               cy_in    = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            copy_v_in    = 1'b1;
            copy_addr_in = {cx_ff, cy_ff};
            if ({1'b0, cy_ff} == h_last) begin
               cy_in = '0;
               if ({1'b0, cx_ff} == w_last) begin
                  state_in = ST_COPY_DRAIN;
               end else begin
                  cx_in = cx_ff + COL_BITS'(1);
               end
            end else begin
               cy_in = cy_ff + ROW_BITS'(1);
            end
         end
         ST_COPY_DRAIN: begin
            live_in      = total_ff;
            gen_in       = gen_ff + GEN_BITS'(1);
            rsp_valid_in = 1'b1;
            rsp_age_in   = '0;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            cur_we    = 1'b1;
            cur_waddr = clr_ff;
            cur_wdata = '0;
            clr_in    = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               live_in      = '0;
               gen_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_age_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // copy back from the scratch grid in the cycle after its read
      if (copy_v_ff) begin
         cur_we    = 1'b1;
         cur_waddr = copy_addr_ff;
         cur_wdata = nxt_rdata;
      end

      if (rule_wr.we && rule_wr.alive && (total_ff != COUNT_MAX)) begin
         total_in = total_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         max_age_ff   <= AGE_BITS'(20);
         grid_w_ff    <= DIM_MAX_W;
         grid_h_ff    <= DIM_MAX_H;
         live_ff      <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         tag_ff       <= '0;
         copy_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_age_ff   <= max_age_in;
         grid_w_ff    <= grid_w_in;
         grid_h_ff    <= grid_h_in;
         live_ff      <= live_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         tag_ff       <= tag_in;
         copy_v_ff    <= copy_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_age_ff   <= rsp_age_in;
      copy_addr_ff <= copy_addr_in;
      func_ff      <= func_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      age_ff       <= age_in;
      col_ff       <= col_in;
      k_ff         <= k_in;
      phase_ff     <= phase_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      drain_ff     <= drain_in;
      total_ff     <= total_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = '{read_age: rsp_age_ff, alive_count: live_ff, generation: gen_ff};

endmodule

FILE: tb/sv/aging_life_automaton_torus_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aging life automaton checker
// Watches the item, result and register channels of the automaton. It keeps
// its own copy of the age grid, the live count and the generation counter,
// works out the result of every accepted item and compares each strobed
// result, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module aging_life_automaton_torus_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  alat_pkg::req_item_type             req_item,
   input  logic                               rsp_strobe,
   input  alat_pkg::rsp_item_type             rsp_item,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [alat_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [alat_pkg::CSR_DATA_BITS-1:0] csr_data,
   output int                                 errors,
   output int                                 pending
);

   import alat_pkg::*;

   localparam int CELL_COUNT  = MAX_WIDTH * MAX_HEIGHT;
   localparam int QUEUE_DEPTH = 8;

   logic [AGE_BITS-1:0]   life_grid [0:CELL_COUNT-1];
   logic [AGE_BITS-1:0]   next_ages [0:CELL_COUNT-1];
   logic [COUNT_BITS-1:0] live_cells;
   logic [GEN_BITS-1:0]   gen_count;
   logic [AGE_BITS-1:0]   age_limit;
   logic [DIM_BITS-1:0]   width_reg;
   logic [DIM_BITS-1:0]   height_reg;
   rsp_item_type          want_fifo [QUEUE_DEPTH];
   int                    fifo_head;
   int                    fifo_tail;
   int                    fifo_fill;

   function automatic int clamp_dim(input logic [DIM_BITS-1:0] raw, input int hi);
      if (raw < 3) return 3;
      if (int'(raw) > hi) return hi;
      return int'(raw);
   endfunction

   function automatic rsp_item_type predict_result(input req_item_type it);
      int w, h, x, y, xl, xr, yu, yd, i, j, n, total;
      int cols [3];
      int rows [3];
      logic [AGE_BITS-1:0] cur_age, new_age;
      rsp_item_type res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      x = int'(it.cell_x) % w;
      y = int'(it.cell_y) % h;
      res = '0;
      case (it.func)
         FUNC_WRITE: life_grid[x * MAX_HEIGHT + y] = it.cell_age;
         FUNC_READ:  res.read_age = life_grid[x * MAX_HEIGHT + y];
         FUNC_GEN: begin
            total = 0;
            for (int cx = 0; cx < w; cx++) begin
               xl = (cx == 0) ? w - 1 : cx - 1;
               xr = (cx + 1 == w) ? 0 : cx + 1;
               for (int cy = 0; cy < h; cy++) begin
                  yu = (cy == 0) ? h - 1 : cy - 1;
                  yd = (cy + 1 == h) ? 0 : cy + 1;
                  cols[0] = xl; cols[1] = cx; cols[2] = xr;
                  rows[0] = yu; rows[1] = cy; rows[2] = yd;
                  n = 0;
                  for (i = 0; i < 3; i++)
                     for (j = 0; j < 3; j++)
                        if ((i != 1 || j != 1) && life_grid[cols[i] * MAX_HEIGHT + rows[j]] != 0)
                           n++;
                  cur_age = life_grid[cx * MAX_HEIGHT + cy];
                  new_age = '0;
                  if (n == 3 || (cur_age != 0 && n == 2))
                     new_age = (cur_age < age_limit) ? cur_age + 1'b1 : age_limit;
                  next_ages[cx * MAX_HEIGHT + cy] = new_age;
                  if (new_age != 0) total++;
               end
            end
            // copy back the active area only; cells outside it keep their ages
            for (int cx = 0; cx < w; cx++)
               for (int cy = 0; cy < h; cy++)
                  life_grid[cx * MAX_HEIGHT + cy] = next_ages[cx * MAX_HEIGHT + cy];
            live_cells = (total > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(total);
            gen_count  = gen_count + 1'b1;
         end
         default: begin
            for (int k = 0; k < CELL_COUNT; k++) life_grid[k] = '0;
            live_cells = '0;
            gen_count  = '0;
         end
      endcase
      res.alive_count = live_cells;
      res.generation  = gen_count;
      return res;
   endfunction

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type fresh;
      if (reset) begin
         for (int k = 0; k < CELL_COUNT; k++) life_grid[k] = '0;
         live_cells = '0;
         gen_count  = '0;
         age_limit  = AGE_BITS'(20);
         width_reg  = DIM_MAX_W;
         height_reg = DIM_MAX_H;
         fifo_head  = 0;
         fifo_tail  = 0;
         fifo_fill  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_AGE: age_limit  = csr_data;
               CSR_GRID_W:  width_reg  = csr_data[DIM_BITS-1:0];
               CSR_GRID_H:  height_reg = csr_data[DIM_BITS-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            fresh = predict_result(req_item);
            if (fifo_fill == QUEUE_DEPTH) begin
               errors++;
               $display("%0t: more than %0d results outstanding", $time, QUEUE_DEPTH);
            end else begin
               want_fifo[fifo_tail] = fresh;
               fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
               fifo_fill++;
            end
         end
         if (rsp_strobe) begin
            if (fifo_fill == 0) begin
               errors++;
               $display("%0t: result with nothing expected: read_age %0d alive_count %0d generation %0d",
                        $time, rsp_item.read_age, rsp_item.alive_count, rsp_item.generation);
            end else begin
               want = want_fifo[fifo_head];
               fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
               fifo_fill--;
               if (rsp_item.read_age !== want.read_age) begin
                  errors++;
                  $display("%0t: read_age expected %0d, got %0d",
                           $time, want.read_age, rsp_item.read_age);
               end
               if (rsp_item.alive_count !== want.alive_count) begin
                  errors++;
                  $display("%0t: alive_count expected %0d, got %0d",
                           $time, want.alive_count, rsp_item.alive_count);
               end
               if (rsp_item.generation !== want.generation) begin
                  errors++;
                  $display("%0t: generation expected %0d, got %0d",
                           $time, want.generation, rsp_item.generation);
               end
            end
         end
      end
      pending = fifo_fill;
   end

endmodule

FILE: tb/sv/aging_life_automaton_torus_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aging life automaton testbench
// Drives directed and random cell writes, reads, generations and clears into
// the automaton over a range of grid sizes and age limits, with random gaps
// between items or, in steady phases, none. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module aging_life_automaton_torus_tb;

   import alat_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 20;
   localparam int SEED_WRITES  = 6;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_item_type             req_item;
   logic                     rsp_strobe;
   rsp_item_type             rsp_item;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   int  errors;
   int  pending;
   int  cycle_count;
   int  cols_in_use;
   int  rows_in_use;
   bit  steady;
   int  items_sent, gens_sent, clears_sent, reads_sent, writes_sent, csr_writes;

   aging_life_automaton_torus dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   aging_life_automaton_torus_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("aging_life_automaton_torus_tb failed");
         $finish;
      end
   end

   function automatic int dim_in_use(input logic [CSR_DATA_BITS-1:0] raw, input int hi);
      int v;
      v = int'(raw[DIM_BITS-1:0]);
      return (v < 3) ? 3 : (v > hi) ? hi : v;
   endfunction

   // hold start across back-to-back items; drop it only for a gap
   task automatic send_item(input logic [1:0] func, input int x, input int y, input int age);
      int gap;
      req_item_type it;
      gap = steady ? 0 : $urandom_range(0, 10);
      it.func     = func;
      it.cell_x   = COL_BITS'(x);
      it.cell_y   = ROW_BITS'(y);
      it.cell_age = AGE_BITS'(age);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      case (func)
         FUNC_WRITE: writes_sent++;
         FUNC_READ:  reads_sent++;
         FUNC_GEN:   gens_sent++;
         default:    clears_sent++;
      endcase
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      while (busy) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_GRID_W: cols_in_use = dim_in_use(data, MAX_WIDTH);
         CSR_GRID_H: rows_in_use = dim_in_use(data, MAX_HEIGHT);
         default: ;
      endcase
   endtask

   initial begin
      int r, x, y, age;
      logic [CSR_DATA_BITS-1:0] raw;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      steady      = 1'b0;
      cols_in_use = MAX_WIDTH;
      rows_in_use = MAX_HEIGHT;
      items_sent = 0; gens_sent = 0; clears_sent = 0;
      reads_sent = 0; writes_sent = 0; csr_writes = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // blinker straddling the x wrap on the full grid; centre written above the limit
      send_item(FUNC_READ, 63, 63, 255);
      send_item(FUNC_WRITE, 63, 0, 7);
      send_item(FUNC_WRITE, 0, 0, 255);
      send_item(FUNC_WRITE, 1, 0, 1);
      send_item(FUNC_GEN, 0, 0, 0);
      send_item(FUNC_READ, 0, 0, 0);
      send_item(FUNC_READ, 0, 63, 0);
      send_item(FUNC_GEN, 63, 63, 255);
      send_item(FUNC_WRITE, 0, 40, 77);

      // undersized height, width with the spare bit set, spare register index
      settle();
      write_csr(CSR_MAX_AGE, 8'd255);
      write_csr(CSR_GRID_W, 8'h85);
      write_csr(CSR_GRID_H, 8'd2);
      write_csr(CSR_SPARE, 8'hAA);
      send_item(FUNC_WRITE, 63, 63, 254);
      send_item(FUNC_WRITE, 2, 1, 1);
      send_item(FUNC_WRITE, 4, 2, 200);
      send_item(FUNC_GEN, 0, 0, 0);
      send_item(FUNC_READ, 63, 63, 0);

      // zero age limit, oversized width, zero height
      settle();
      write_csr(CSR_MAX_AGE, 8'd0);
      write_csr(CSR_GRID_W, 8'd127);
      write_csr(CSR_GRID_H, 8'd0);
      send_item(FUNC_WRITE, 10, 1, 9);
      send_item(FUNC_WRITE, 11, 1, 9);
      send_item(FUNC_WRITE, 12, 1, 9);
      send_item(FUNC_GEN, 0, 0, 0);
      send_item(FUNC_READ, 11, 1, 0);

      // back to full size: the cell outside both small areas must have kept its age
      settle();
      write_csr(CSR_MAX_AGE, 8'd1);
      write_csr(CSR_GRID_W, 8'd64);
      write_csr(CSR_GRID_H, 8'd64);
      send_item(FUNC_READ, 0, 40, 0);
      send_item(FUNC_CLEAR, 0, 40, 0);
      send_item(FUNC_READ, 0, 40, 0);
      send_item(FUNC_GEN, 0, 0, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 3))
            0:       raw = 8'($urandom_range(0, 255));
            default: raw = 8'($urandom_range(1, 6));
         endcase
         write_csr(CSR_MAX_AGE, raw);
         if ($urandom_range(0, 4) == 0) raw = 8'($urandom_range(0, 255));
         else raw = 8'($urandom_range(3, 10)) | 8'($urandom_range(0, 1) << 7);
         write_csr(CSR_GRID_W, raw);
         // keep generations cheap: a wide grid gets a short height
         if (cols_in_use > 16 || $urandom_range(0, 4) != 0)
            raw = 8'($urandom_range(0, 10)) | 8'($urandom_range(0, 1) << 7);
         else
            raw = 8'($urandom_range(0, 255));
         write_csr(CSR_GRID_H, raw);
         steady = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = (k < SEED_WRITES) ? 0 : $urandom_range(0, 99);
            x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, cols_in_use - 1);
            y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, rows_in_use - 1);
            case ($urandom_range(0, 5))
               0:       age = 0;
               1:       age = 255;
               default: age = $urandom_range(1, 8);
            endcase
            if (r < 40)      send_item(FUNC_WRITE, x, y, age);
            else if (r < 70) send_item(FUNC_READ, x, y, age);
            else if (r < 96) send_item(FUNC_GEN, x, y, age);
            else             send_item(FUNC_CLEAR, x, y, age);
         end
      end
      steady = 1'b0;

      settle();
      repeat (30) @(posedge clock);
      $display("Sent %0d items: %0d writes, %0d reads, %0d generations, %0d clears",
               items_sent, writes_sent, reads_sent, gens_sent, clears_sent);
      $display("Made %0d register writes across grid sizes from 3x3 to 64x64", csr_writes);
      if (errors == 0)
         $display("aging_life_automaton_torus_tb passed");
      else
         $display("aging_life_automaton_torus_tb failed");
      $finish;
   end

endmodule
